// ----- src/lrbm_pkg.sv -----
package lrbm_pkg;

  localparam int NUM_ENTRIES_DEF = 32;
  localparam int STAMP_BITS_DEF  = 32;
  localparam int TOTAL_W         = 40;
  localparam int SIZE_W          = 32;
  localparam int ENTRY_W         = 5;
  localparam int MAX_EVICT_RPT   = 32;

  localparam logic [1:0] KIND_REGISTER = 2'd0;
  localparam logic [1:0] KIND_REQUIRE  = 2'd1;
  localparam logic [1:0] KIND_DIRTY    = 2'd2;
  localparam logic [1:0] KIND_OFFLOAD  = 2'd3;

  localparam logic [2:0] ACT_DONE    = 3'd0;
  localparam logic [2:0] ACT_EVICTED = 3'd1;
  localparam logic [2:0] ACT_LOADED  = 3'd2;
  localparam logic [2:0] ACT_TOO_BIG = 3'd3;
  localparam logic [2:0] ACT_UNKNOWN = 3'd4;
  localparam logic [2:0] ACT_DUP     = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ENTRY_W-1:0] entry;
    logic [SIZE_W-1:0]  entry_bytes;
    logic               keep_resident;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [ENTRY_W-1:0] target;
    logic               write_back;
    logic [TOTAL_W-1:0] resident_total;
    logic               last;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    in_item_t item;
    logic     in_range;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_REG2, S_RQ_RD, S_CHK, S_SCAN, S_SCAN_END,
    S_EVICT, S_LOAD, S_OFF_RD, S_OFF_EV, S_OFF_DONE
  } state_t;

endpackage

// ----- src/lrbm_ram.sv -----
module lrbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- src/lrbm_fifo.sv -----
module lrbm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wdata;
    end
  end
endmodule

// ----- src/lrbm_front.sv -----
module lrbm_front #(
  parameter int NUM_ENTRIES = lrbm_pkg::NUM_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lrbm_pkg::in_item_t in_item,
  output logic              full,
  input  logic              cmd_pop,
  output lrbm_pkg::cmd_t    cmd_head,
  output logic              cmd_empty
);
  import lrbm_pkg::*;

  cmd_t cmd_in;

  // tag entries that lie outside the table
  always_comb begin
    cmd_in.item     = in_item;
    cmd_in.in_range = (int'(in_item.entry) < NUM_ENTRIES);
  end

  lrbm_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );
endmodule

// ----- src/lrbm_back.sv -----
module lrbm_back #(
  parameter int NUM_ENTRIES = lrbm_pkg::NUM_ENTRIES_DEF,
  parameter int STAMP_BITS  = lrbm_pkg::STAMP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lrbm_pkg::TOTAL_W-1:0]   budget,
  input  lrbm_pkg::cmd_t                 cmd_head,
  input  logic                           cmd_empty,
  output logic                           cmd_pop,
  output logic                           res_push,
  output lrbm_pkg::out_item_t            res,
  input  logic                           res_full
);
  import lrbm_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int EVC_W = $clog2(MAX_EVICT_RPT + 1);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;

  logic [NUM_ENTRIES-1:0] valid_r, resident_r, dirty_r;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic [STAMP_BITS-1:0]  tick_r, tick_nxt;
  logic [SIZE_W-1:0]      need_r;
  logic [IDX_W-1:0]       scan_r, pidx_r, best_r;
  logic                   pv_r, found_r;
  logic [STAMP_BITS-1:0]  best_stamp_r;
  logic [SIZE_W-1:0]      best_size_r;
  logic [EVC_W-1:0]       evc_r;

  logic [IDX_W-1:0]       e_idx, raddr;
  logic                   known, adv, size_we, stamp_we, off_hit, cand;
  logic [SIZE_W-1:0]      size_rdata;
  logic [STAMP_BITS-1:0]  stamp_rdata;

  assign e_idx    = IDX_W'(cmd_r.item.entry);
  assign known    = cmd_r.in_range && valid_r[e_idx];
  assign tick_nxt = (tick_r == STAMP_MAX) ? tick_r : tick_r + 1'b1;
  assign off_hit  = valid_r[scan_r] && resident_r[scan_r];
  assign cand     = pv_r && valid_r[pidx_r] && resident_r[pidx_r] && (pidx_r != e_idx);

  function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] a,
                                                 input logic [SIZE_W-1:0]  b);
    logic [TOTAL_W-1:0] bw;
    bw = TOTAL_W'(b);
    return (a >= bw) ? a - bw : '0;
  endfunction

  lrbm_ram #(.WIDTH(SIZE_W), .DEPTH(NUM_ENTRIES)) u_size_ram (
    .clk(clk), .we(size_we), .waddr(e_idx), .wdata(cmd_r.item.entry_bytes),
    .raddr(raddr), .rdata(size_rdata)
  );

  lrbm_ram #(.WIDTH(STAMP_BITS), .DEPTH(NUM_ENTRIES)) u_stamp_ram (
    .clk(clk), .we(stamp_we), .waddr(e_idx), .wdata(tick_nxt),
    .raddr(raddr), .rdata(stamp_rdata)
  );

  // outputs per state
  always_comb begin
    logic sw, zw;
    sw        = 1'b0;
    zw        = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    res.target = cmd_r.item.entry;
    cmd_pop   = 1'b0;
    raddr     = scan_r;
    total_nxt = total_r;
    unique case (state_r)
      S_IDLE: cmd_pop = !cmd_empty;
      S_DEC: begin
        raddr = e_idx;
        unique case (cmd_r.item.kind)
          KIND_REGISTER: begin
            res_push = 1'b1;
            if (!cmd_r.in_range) begin
              res.action = ACT_UNKNOWN;
            end else if (valid_r[e_idx]) begin
              res.action = ACT_DUP;
            end else begin
              res.action     = ACT_EVICTED;
              res.write_back = 1'b1;
              res.last       = !cmd_r.item.keep_resident;
              sw = 1'b1;
              zw = 1'b1;
            end
          end
          KIND_REQUIRE: begin
            res_push   = !known;
            res.action = ACT_UNKNOWN;
          end
          KIND_DIRTY: begin
            res_push   = 1'b1;
            res.action = known ? ACT_DONE : ACT_UNKNOWN;
          end
          KIND_OFFLOAD: ;
          default: ;
        endcase
      end
      S_REG2: begin
        res_push   = 1'b1;
        res.action = ACT_LOADED;
        total_nxt  = total_r + TOTAL_W'(cmd_r.item.entry_bytes);
      end
      S_RQ_RD: begin
        raddr = e_idx;
        if (TOTAL_W'(size_rdata) > budget) begin
          res_push   = 1'b1;
          res.action = ACT_TOO_BIG;
        end else if (resident_r[e_idx]) begin
          res_push   = 1'b1;
          res.action = ACT_DONE;
          sw         = 1'b1;
        end
      end
      S_CHK, S_SCAN, S_SCAN_END, S_OFF_RD: ;
      S_EVICT: begin
        if (found_r) begin
          res_push       = 1'b1;
          res.action     = ACT_EVICTED;
          res.target     = ENTRY_W'(best_r);
          res.write_back = dirty_r[best_r];
          res.last       = 1'b0;
          total_nxt      = sat_sub(total_r, best_size_r);
        end
      end
      S_LOAD: begin
        res_push   = 1'b1;
        res.action = ACT_LOADED;
        total_nxt  = total_r + TOTAL_W'(need_r);
        sw         = 1'b1;
      end
      S_OFF_EV: begin
        if (off_hit) begin
          res_push       = (evc_r < EVC_W'(MAX_EVICT_RPT));
          res.action     = ACT_EVICTED;
          res.target     = ENTRY_W'(scan_r);
          res.write_back = dirty_r[scan_r];
          res.last       = 1'b0;
          total_nxt      = sat_sub(total_r, size_rdata);
        end
      end
      S_OFF_DONE: begin
        res_push   = 1'b1;
        res.action = ACT_DONE;
        res.target = '0;
        total_nxt  = '0;
      end
      default: ;
    endcase
    res.resident_total = total_nxt;
    adv      = (state_r == S_IDLE) ? !cmd_empty : (!res_push || !res_full);
    res_push = res_push && !res_full;
    stamp_we = sw && adv;
    size_we  = zw && adv;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (adv) begin
      unique case (state_r)
        S_IDLE: state_nxt = S_DEC;
        S_DEC: begin
          unique case (cmd_r.item.kind)
            KIND_REGISTER: state_nxt = (cmd_r.in_range && !valid_r[e_idx] &&
                                        cmd_r.item.keep_resident) ? S_REG2 : S_IDLE;
            KIND_REQUIRE:  state_nxt = known ? S_RQ_RD : S_IDLE;
            KIND_DIRTY:    state_nxt = S_IDLE;
            KIND_OFFLOAD:  state_nxt = S_OFF_RD;
            default:       state_nxt = S_IDLE;
          endcase
        end
        S_REG2: state_nxt = S_IDLE;
        S_RQ_RD: state_nxt = res_push ? S_IDLE : S_CHK;
        S_CHK: state_nxt = (({1'b0, total_r} + (TOTAL_W + 1)'(need_r)) >
                            {1'b0, budget}) ? S_SCAN : S_LOAD;
        S_SCAN: state_nxt = (scan_r == IDX_W'(NUM_ENTRIES - 1)) ? S_SCAN_END : S_SCAN;
        S_SCAN_END: state_nxt = S_EVICT;
        S_EVICT: state_nxt = found_r ? S_CHK : S_LOAD;
        S_LOAD: state_nxt = S_IDLE;
        S_OFF_RD: state_nxt = S_OFF_EV;
        S_OFF_EV: state_nxt = (scan_r == IDX_W'(NUM_ENTRIES - 1)) ? S_OFF_DONE : S_OFF_RD;
        S_OFF_DONE: state_nxt = S_IDLE;
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      resident_r <= '0;
      dirty_r    <= '0;
      total_r    <= '0;
      tick_r     <= '0;
      pv_r       <= 1'b0;
      found_r    <= 1'b0;
      scan_r     <= '0;
      evc_r      <= '0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= (state_r == S_SCAN);
      if (adv) begin
        total_r <= total_nxt;
      end
      if (stamp_we) begin
        tick_r <= tick_nxt;
      end
      unique case (state_r)
        S_DEC: begin
          scan_r <= '0;
          evc_r  <= '0;
          if (adv && size_we) begin
            valid_r[e_idx]    <= 1'b1;
            dirty_r[e_idx]    <= 1'b0;
            resident_r[e_idx] <= 1'b0;
          end
          if (cmd_r.item.kind == KIND_DIRTY && known && adv) begin
            dirty_r[e_idx] <= 1'b1;
          end
        end
        S_REG2: if (adv) resident_r[e_idx] <= 1'b1;
        S_CHK: begin
          scan_r  <= '0;
          found_r <= 1'b0;
        end
        S_SCAN: scan_r <= scan_r + 1'b1;
        S_EVICT: begin
          if (adv && found_r) begin
            resident_r[best_r] <= 1'b0;
            dirty_r[best_r]    <= 1'b0;
          end
        end
        S_LOAD: if (adv) resident_r[e_idx] <= 1'b1;
        S_OFF_EV: begin
          if (adv) begin
            if (off_hit) begin
              resident_r[scan_r] <= 1'b0;
              if (res_push) evc_r <= evc_r + 1'b1;
            end
            scan_r <= scan_r + 1'b1;
          end
        end
        S_OFF_DONE: begin
          if (adv) begin
            resident_r <= '0;
            dirty_r    <= '0;
          end
        end
        default: ;
      endcase
      // victim search, one entry a cycle, using the registered copy of the read address
      if (cand && (!found_r || stamp_rdata < best_stamp_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && adv) begin
      cmd_r <= cmd_head;
    end
    if (state_r == S_RQ_RD) begin
      need_r <= size_rdata;
    end
    pidx_r <= scan_r;
    if (cand && (!found_r || stamp_rdata < best_stamp_r)) begin
      best_r       <= pidx_r;
      best_stamp_r <= stamp_rdata;
      best_size_r  <= size_rdata;
    end
  end
endmodule

// ----- src/lru_residency_budget_manager_unit.sv -----
// LRU residency manager under a resident-byte budget. Push an operation
// (register, require, mark dirty, offload all) while full is low; each
// operation yields one or more results, the final one flagged by last, and
// they are read with empty/pop. Operations run one at a time. A require
// miss evicts resident entries while the entry does not fit the budget and
// a victim remains, and every eviction reads the stamp and size memories
// once per entry to find the oldest resident entry. Offload all reads and
// checks each table entry in turn. A full result queue stalls the back
// until a result is popped. The budget register may only be written while
// no operation is in progress.
module lru_residency_budget_manager_unit #(
  parameter int NUM_ENTRIES = lrbm_pkg::NUM_ENTRIES_DEF,
  parameter int STAMP_BITS  = lrbm_pkg::STAMP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // operation transfer
  input  logic                         push,
  input  lrbm_pkg::in_item_t           in_item,
  output logic                         full,
  // result transfer
  output logic                         empty,
  input  logic                         pop,
  output lrbm_pkg::out_item_t          out_item,
  // budget register
  input  logic                         cfg_we,
  input  logic [lrbm_pkg::TOTAL_W-1:0] cfg_wdata
);
  import lrbm_pkg::*;

  logic [TOTAL_W-1:0] budget_r;
  cmd_t               cmd_head;
  logic               cmd_empty, cmd_pop;
  logic               res_push, res_full;
  out_item_t          res;

  // budget register, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
    end else if (cfg_we) begin
      budget_r <= cfg_wdata;
    end
  end

  // front: accept and range-classify operations into a short queue
  lrbm_front #(.NUM_ENTRIES(NUM_ENTRIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty)
  );

  // back: table state, victim search and result generation
  lrbm_back #(.NUM_ENTRIES(NUM_ENTRIES), .STAMP_BITS(STAMP_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .budget    (budget_r),
    .cmd_head  (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // result queue decouples the back from the consumer
  lrbm_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );
endmodule
